// ----- rtl/core/rawa_pkg.sv -----
// Package for the replica-aware work assigner: item types, codes and state encoding.
// Depends on nothing; every module of the block imports it.
package rawa_pkg;

   // Input item: what is asked, for which node and which fragment.
   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] node;
      logic [5:0] fragment;
   } req_type;

   // Result item: the kind of work handed out and the fragment concerned.
   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] fragment_out;
   } rsp_type;

   // Item modes.
   localparam logic [1:0] MODE_HOLD      = 2'd0;
   localparam logic [1:0] MODE_REQUEST   = 2'd1;
   localparam logic [1:0] MODE_COPY_DONE = 2'd2;

   // Result operations.
   localparam logic [1:0] OP_SEARCH   = 2'd0;
   localparam logic [1:0] OP_COPY     = 2'd1;
   localparam logic [1:0] OP_COMPLETE = 2'd2;

   // Fragment count register.
   localparam int         CSR_W     = 7;
   localparam logic [6:0] CSR_RESET = 7'd64;

   // Outcome of one pass over the table.
   typedef struct packed {
      logic search_found;
      logic copy_found;
   } scan_flags_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_FIX_RD,
      ST_FIX_WR
   } state_type;

endpackage

// ----- rtl/core/rawa_table.sv -----
// Fragment table storage: one synchronous memory, one write and one read port.
// Read data is registered, so it appears in the cycle after the address.
module rawa_table
   import rawa_pkg::*;
#(
   parameter int WIDTH = 71,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rawa_scan.sv -----
// Selection unit: follows the table entries streamed out of memory, one per cycle,
// and keeps the best search candidate and the best copy candidate. Uses rawa_pkg.
module rawa_scan
   import rawa_pkg::*;
#(
   parameter int NODES = 32,
   parameter int FW    = 6,
   parameter int RW    = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clr,
   input  logic                 vld,
   input  logic [FW-1:0]        idx,
   input  logic [NODES-1:0]     holder,
   input  logic [NODES-1:0]     copier,
   input  logic                 unas,
   input  logic [RW-1:0]        rep,
   input  logic [NODES-1:0]     node_bit,
   output scan_flags_type       flags,
   output logic [FW-1:0]        search_idx,
   output logic [FW-1:0]        copy_idx
);

   logic          s_found_ff;
   logic          c_found_ff;
   logic [FW-1:0] s_idx_ff;
   logic [FW-1:0] c_idx_ff;
   logic [RW-1:0] s_rep_ff;
   logic [RW-1:0] c_rep_ff;
   logic          s_hit;
   logic          c_hit;
   logic          s_upd;
   logic          c_upd;

   // A search candidate is unassigned and held by the node; a copy candidate is
   // unassigned and nobody copies it. Strictly fewer holders wins, so ties keep the
   // lower index. An orphan has no holders, so the first orphan always wins.
   always_comb begin
      s_hit = vld && unas && (|(holder & node_bit));
      c_hit = vld && unas && !(|copier);
      s_upd = s_hit && (!s_found_ff || (rep < s_rep_ff));
      c_upd = c_hit && (!c_found_ff || (rep < c_rep_ff));
   end

   // Found flags, cleared at the start of each pass.
   always_ff @(posedge clock) begin
      if (reset || clr) begin
         s_found_ff <= 1'b0;
         c_found_ff <= 1'b0;
      end else begin
         if (s_upd) begin
            s_found_ff <= 1'b1;
         end
         if (c_upd) begin
            c_found_ff <= 1'b1;
         end
      end
   end

   // Best index and its replica count.
   always_ff @(posedge clock) begin
      if (s_upd) begin
         s_idx_ff <= idx;
         s_rep_ff <= rep;
      end
      if (c_upd) begin
         c_idx_ff <= idx;
         c_rep_ff <= rep;
      end
   end

   assign flags.search_found = s_found_ff;
   assign flags.copy_found   = c_found_ff;
   assign search_idx         = s_idx_ff;
   assign copy_idx           = c_idx_ff;

endmodule

// ----- rtl/core/replica_aware_work_assigner.sv -----
// Replica-aware work assigner: top level with the sequencer and configuration register.
// Depends on rawa_pkg, rawa_table (fragment table) and rawa_scan (selection unit).
//
// Usage. An item (req) is taken at a clock edge where start is high and busy is low.
// Mode hold records that a node holds a fragment, mode copy-done makes the node a
// holder and clears its copier mark; neither gives a result and both keep busy high
// through a read, then a write back of one table entry. Mode request gives exactly
// one result item on rsp, shown for one cycle with rsp_strobe high; the receiver
// cannot hold it off. A request scans the N active fragments (N = min of
// csr_wr_data last written and FRAGMENTS), one table entry per cycle through the
// memory read port, then rereads and updates the chosen entry; rsp_strobe is
// registered from the state that writes that entry back. When no fragment qualifies,
// there is no reread or update and complete is registered from the decide state. A request
// for a node out of range, or with no active fragments, answers complete on the
// next cycle without going busy. The fragment count register is written with
// csr_wr_en at any edge and must only change while the block is idle.
// After reset the block clears the table, one entry per cycle, and holds busy high
// until every entry is cleared; the count register resets to 64.
module replica_aware_work_assigner
   import rawa_pkg::*;
#(
   parameter int FRAGMENTS = 64,
   parameter int NODES     = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req,
   output logic             rsp_strobe,
   output rsp_type          rsp,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   localparam int FW = $clog2(FRAGMENTS);
   localparam int CW = $clog2(FRAGMENTS + 1);
   localparam int RW = $clog2(NODES + 1);

   // Table entry layout: holders, copiers, unassigned flag, replica count.
   localparam int UNAS_BIT = RW;
   localparam int COP_LSB  = RW + 1;
   localparam int HOLD_LSB = RW + 1 + NODES;
   localparam int EW       = RW + 1 + 2 * NODES;
   localparam logic [EW-1:0] CLEAR_ENTRY = {{(2 * NODES){1'b0}}, 1'b1, {RW{1'b0}}};

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [FW-1:0]    idx_ff, idx_in;
   logic [CSR_W-1:0] csr_ff;
   logic [FW-1:0]    pick_idx_ff, pick_idx_in;
   logic [1:0]       pick_op_ff, pick_op_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;
   logic             scan_vld_ff;
   logic [FW-1:0]    scan_idx_ff;

   logic [CW-1:0]    act_cnt;
   logic             node_ok;
   logic             frag_ok;
   logic             last_idx;
   logic [NODES-1:0] node_bit;

   logic             tbl_wr_en;
   logic [FW-1:0]    tbl_wr_addr;
   logic [EW-1:0]    tbl_wr_data;
   logic             tbl_rd_en;
   logic [FW-1:0]    tbl_rd_addr;
   logic [EW-1:0]    tbl_rd_data;

   logic [NODES-1:0] rd_holder;
   logic [NODES-1:0] rd_copier;
   logic             rd_unas;
   logic [RW-1:0]    rd_rep;
   logic [EW-1:0]    upd_entry;
   logic [EW-1:0]    fix_entry;

   logic             scan_clr;
   scan_flags_type   scan_flags;
   logic [FW-1:0]    search_idx;
   logic [FW-1:0]    copy_idx;

   // Fragment table.
   rawa_table #(
      .WIDTH (EW),
      .DEPTH (FRAGMENTS),
      .AW    (FW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // Selection over the entries streamed out during a request.
   rawa_scan #(
      .NODES (NODES),
      .FW    (FW),
      .RW    (RW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clr        (scan_clr),
      .vld        (scan_vld_ff),
      .idx        (scan_idx_ff),
      .holder     (rd_holder),
      .copier     (rd_copier),
      .unas       (rd_unas),
      .rep        (rd_rep),
      .node_bit   (node_bit),
      .flags      (scan_flags),
      .search_idx (search_idx),
      .copy_idx   (copy_idx)
   );

   // Active fragment count, limited to the table size, and range checks.
   always_comb begin
      if (32'(csr_ff) > 32'(FRAGMENTS)) begin
         act_cnt = CW'(FRAGMENTS);
      end else begin
         act_cnt = CW'(csr_ff);
      end
      node_ok  = 32'(req.node) < 32'(NODES);
      frag_ok  = 32'(req.fragment) < 32'(act_cnt);
      last_idx = 32'(idx_ff) == (32'(act_cnt) - 32'd1);
      node_bit = {{(NODES - 1){1'b0}}, 1'b1} << req_ff.node;
   end

   // Entry read back and its two kinds of update.
   always_comb begin
      rd_holder = tbl_rd_data[HOLD_LSB +: NODES];
      rd_copier = tbl_rd_data[COP_LSB +: NODES];
      rd_unas   = tbl_rd_data[UNAS_BIT];
      rd_rep    = tbl_rd_data[RW-1:0];

      // Holding or copy done: add the holder once, drop the copier mark on copy done.
      upd_entry = tbl_rd_data;
      upd_entry[HOLD_LSB +: NODES] = rd_holder | node_bit;
      if (!(|(rd_holder & node_bit))) begin
         upd_entry[RW-1:0] = rd_rep + RW'(1);
      end
      if (req_ff.mode == MODE_COPY_DONE) begin
         upd_entry[COP_LSB +: NODES] = rd_copier & ~node_bit;
      end

      // Chosen fragment: a search assignment clears the flag, a copy task marks the copier.
      fix_entry = tbl_rd_data;
      if (pick_op_ff == OP_SEARCH) begin
         fix_entry[UNAS_BIT] = 1'b0;
      end else begin
         fix_entry[COP_LSB +: NODES] = rd_copier | node_bit;
      end
   end

   // Sequencer: next state, table accesses and result.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      pick_idx_in   = pick_idx_ff;
      pick_op_in    = pick_op_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      scan_clr      = 1'b0;
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = idx_ff;
      tbl_wr_data   = CLEAR_ENTRY;
      tbl_rd_en     = 1'b0;
      tbl_rd_addr   = idx_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            tbl_wr_en = 1'b1;
            if (32'(idx_ff) == 32'(FRAGMENTS - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + FW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in = req;
               priority if (req.mode == MODE_REQUEST) begin
                  if (!node_ok || (act_cnt == '0)) begin
                     rsp_strobe_in       = 1'b1;
                     rsp_in.operation    = OP_COMPLETE;
                     rsp_in.fragment_out = '0;
                  end else begin
                     idx_in   = '0;
                     scan_clr = 1'b1;
                     state_in = ST_SCAN;
                  end
               end else if ((req.mode == MODE_HOLD || req.mode == MODE_COPY_DONE)
                            && node_ok && frag_ok) begin
                  state_in = ST_UPD_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_UPD_RD: begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = FW'(req_ff.fragment);
            state_in    = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = FW'(req_ff.fragment);
            tbl_wr_data = upd_entry;
            state_in    = ST_IDLE;
         end
         ST_SCAN: begin
            tbl_rd_en = 1'b1;
            if (last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + FW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (scan_flags.search_found) begin
               pick_idx_in = search_idx;
               pick_op_in  = OP_SEARCH;
               state_in    = ST_FIX_RD;
            end else if (scan_flags.copy_found) begin
               pick_idx_in = copy_idx;
               pick_op_in  = OP_COPY;
               state_in    = ST_FIX_RD;
            end else begin
               rsp_strobe_in       = 1'b1;
               rsp_in.operation    = OP_COMPLETE;
               rsp_in.fragment_out = '0;
               state_in            = ST_IDLE;
            end
         end
         ST_FIX_RD: begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = pick_idx_ff;
            state_in    = ST_FIX_WR;
         end
         ST_FIX_WR: begin
            tbl_wr_en           = 1'b1;
            tbl_wr_addr         = pick_idx_ff;
            tbl_wr_data         = fix_entry;
            rsp_strobe_in       = 1'b1;
            rsp_in.operation    = pick_op_ff;
            rsp_in.fragment_out = 6'(pick_idx_ff);
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         scan_vld_ff   <= 1'b0;
         csr_ff        <= CSR_RESET;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
         scan_vld_ff   <= (state_ff == ST_SCAN);
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pick_idx_ff <= pick_idx_in;
      pick_op_ff  <= pick_op_in;
      rsp_ff      <= rsp_in;
      scan_idx_ff <= idx_ff;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   // A result only follows an immediate answer, the end of a pass or a final update.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_IDLE || $past(state_ff) == ST_DECIDE
                      || $past(state_ff) == ST_FIX_WR))
      else $error("result strobe without a finished item");

   // The table is never written while a pass streams entries out.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> !tbl_wr_en)
      else $error("table written during a scan");

   // The fragment picked by a pass is still unassigned when it is updated.
   a_pick_unassigned: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIX_WR |-> rd_unas)
      else $error("picked fragment is already assigned");

   // Entries fed to the selection unit lie inside the active range.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      scan_vld_ff |-> (32'(scan_idx_ff) < 32'(act_cnt)))
      else $error("scan beyond active fragments");

endmodule

// ----- dv/rawa_checker.sv -----
// Checker for the replica-aware work assigner: watches the item and result channels,
// keeps its own copy of the fragment table and compares every answer in order.
// Depends on rawa_pkg for the item types, modes and operation codes.
module rawa_checker
   import rawa_pkg::*;
#(
   parameter int FRAGMENTS = 64,
   parameter int NODES     = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_type          req,
   input  logic             rsp_strobe,
   input  rsp_type          rsp,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   output int               mismatches,
   output int               outstanding,
   output int               searches_seen,
   output int               copies_seen,
   output int               completes_seen
);

   // Shadow of the fragment table and of the count register.
   logic [NODES-1:0] holders    [FRAGMENTS];
   logic [NODES-1:0] copiers    [FRAGMENTS];
   bit               unassigned [FRAGMENTS];
   logic [CSR_W-1:0] count_shadow;

   // Answers predicted but not yet seen on the result port, oldest first.
   rsp_type answers_due [$];

   int errors     = 0;
   int n_search   = 0;
   int n_copy     = 0;
   int n_complete = 0;

   // Counts above the table size behave as the table size.
   function automatic int active_fragments();
      return (int'(count_shadow) > FRAGMENTS) ? FRAGMENTS : int'(count_shadow);
   endfunction

   // Decides the work handed to a requesting node and updates the table to match.
   function automatic rsp_type assign_work(input logic [4:0] node);
      rsp_type answer;
      int      limit;
      int      best;
      int      best_rep;
      int      rep;
      bit      found;
      answer.operation    = OP_COMPLETE;
      answer.fragment_out = '0;
      limit    = active_fragments();
      best     = 0;
      best_rep = 0;
      found    = 1'b0;
      if (int'(node) >= NODES) begin
         return answer;
      end
      // Search: the least replicated unassigned fragment that this node holds.
      for (int f = 0; f < limit; f++) begin
         rep = $countones(holders[f]);
         if (unassigned[f] && holders[f][node] && (!found || rep < best_rep)) begin
            found    = 1'b1;
            best     = f;
            best_rep = rep;
         end
      end
      if (found) begin
         unassigned[best]    = 1'b0;
         answer.operation    = OP_SEARCH;
         answer.fragment_out = 6'(best);
         return answer;
      end
      // Copy: an orphaned fragment at once, else the least replicated uncopied one.
      // A copy task leaves the fragment unassigned.
      for (int f = 0; f < limit; f++) begin
         rep = $countones(holders[f]);
         if (unassigned[f] && copiers[f] == '0) begin
            if (rep == 0) begin
               copiers[f][node]    = 1'b1;
               answer.operation    = OP_COPY;
               answer.fragment_out = 6'(f);
               return answer;
            end
            if (!found || rep < best_rep) begin
               found    = 1'b1;
               best     = f;
               best_rep = rep;
            end
         end
      end
      if (found) begin
         copiers[best][node] = 1'b1;
         answer.operation    = OP_COPY;
         answer.fragment_out = 6'(best);
      end
      return answer;
   endfunction

   // Compare results first, then take in the item and any register write of this edge.
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         for (int f = 0; f < FRAGMENTS; f++) begin
            holders[f]    = '0;
            copiers[f]    = '0;
            unassigned[f] = 1'b1;
         end
         count_shadow = CSR_RESET;
         answers_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               errors++;
               $display("%0t: result with no request waiting: expected none, got op %0d frag %0d",
                        $time, rsp.operation, rsp.fragment_out);
            end else begin
               due = answers_due.pop_front();
               if (rsp.operation !== due.operation) begin
                  errors++;
                  $display("%0t: operation: expected %0d, got %0d",
                           $time, due.operation, rsp.operation);
               end
               if (rsp.fragment_out !== due.fragment_out) begin
                  errors++;
                  $display("%0t: fragment_out: expected %0d, got %0d",
                           $time, due.fragment_out, rsp.fragment_out);
               end
            end
         end
         if (start && !busy) begin
            case (req.mode)
               MODE_HOLD, MODE_COPY_DONE: begin
                  if (int'(req.node) < NODES && int'(req.fragment) < active_fragments()) begin
                     holders[req.fragment][req.node] = 1'b1;
                     if (req.mode == MODE_COPY_DONE) begin
                        copiers[req.fragment][req.node] = 1'b0;
                     end
                  end
               end
               MODE_REQUEST: begin
                  due = assign_work(req.node);
                  answers_due = {answers_due, due};
                  case (due.operation)
                     OP_SEARCH: n_search++;
                     OP_COPY:   n_copy++;
                     default:   n_complete++;
                  endcase
               end
               default: ;
            endcase
         end
         if (csr_wr_en) begin
            count_shadow = csr_wr_data;
         end
      end
      mismatches     <= errors;
      outstanding    <= answers_due.size();
      searches_seen  <= n_search;
      copies_seen    <= n_copy;
      completes_seen <= n_complete;
   end

endmodule

// ----- dv/replica_aware_work_assigner_tb.sv -----
// Testbench top for the replica-aware work assigner: drives items and count settings.
// Depends on rawa_pkg, the block replica_aware_work_assigner and the rawa_checker module.
module replica_aware_work_assigner_tb;
   import rawa_pkg::*;

   localparam int FRAGMENTS = 64;
   localparam int NODES     = 32;
   localparam int PHASES    = 8;

   // The block has no use for this mode; it must ignore such items.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   req_type          req         = '0;
   logic             csr_wr_en   = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = CSR_RESET;
   logic             busy;
   logic             rsp_strobe;
   rsp_type          rsp;

   int mismatches;
   int outstanding;
   int searches_seen;
   int copies_seen;
   int completes_seen;

   // Fragment counts run from empty upwards so that fresh fragments keep appearing.
   int unsigned phase_count [PHASES] = '{0, 1, 2, 6, 16, 33, 127, 64};
   int          phase_quota [PHASES] = '{40, 100, 120, 200, 250, 330, 330, 170};

   bit idle_on       = 1'b1;
   int items_sent    = 0;
   int items_ignored = 0;

   replica_aware_work_assigner #(
      .FRAGMENTS (FRAGMENTS),
      .NODES     (NODES)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rawa_checker #(
      .FRAGMENTS (FRAGMENTS),
      .NODES     (NODES)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req            (req),
      .rsp_strobe     (rsp_strobe),
      .rsp            (rsp),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .searches_seen  (searches_seen),
      .copies_seen    (copies_seen),
      .completes_seen (completes_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block stops answering.
   initial begin
      #10_000_000;
      $display("Run timed out with %0d answers still due.", outstanding);
      $display("Mismatches found");
      $finish;
   end

   function automatic req_type item_of(input logic [1:0] mode, input int node, input int frag);
      req_type r;
      r.mode     = mode;
      r.node     = 5'(node);
      r.fragment = 6'(frag);
      return r;
   endfunction

   // Mostly well-formed work on a few busy nodes, with some noise the block should ignore.
   function automatic req_type random_item(input int active, output bit ignored);
      req_type r;
      int      roll;
      roll       = $urandom_range(99);
      r.node     = ($urandom_range(99) < 70) ? 5'($urandom_range(3))
                                             : 5'($urandom_range(NODES - 1));
      r.fragment = (active > 0 && $urandom_range(99) < 85) ? 6'($urandom_range(active - 1))
                                                           : 6'($urandom_range(63));
      if (roll < 30) begin
         r.mode = MODE_HOLD;
      end else if (roll < 62) begin
         r.mode = MODE_REQUEST;
      end else if (roll < 90) begin
         r.mode = MODE_COPY_DONE;
      end else if (roll < 95 || active >= FRAGMENTS) begin
         r.mode = MODE_UNUSED;
      end else begin
         r.mode     = roll[0] ? MODE_HOLD : MODE_COPY_DONE;
         r.fragment = 6'($urandom_range(63, active));
      end
      ignored = (r.mode == MODE_UNUSED) ||
                (r.mode != MODE_REQUEST && int'(r.fragment) >= active);
      return r;
   endfunction

   // Presents one item, after a random gap, and returns on the edge that takes it.
   task automatic send_item(input req_type item);
      int gaps;
      gaps = 0;
      if (idle_on) begin
         while ($urandom_range(99) < 15) begin
            gaps++;
         end
      end
      if (gaps > 0) begin
         start <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      start <= 1'b1;
      req   <= item;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Changes the fragment count once every answer is in and the block has gone quiet.
   task automatic set_fragment_count(input int unsigned value);
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0 || busy);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CSR_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      req_type item;
      bit      ignored;
      int      useful;
      int      active;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // The block clears its table after reset and stays busy meanwhile.
      do begin
         @(posedge clock);
      end while (busy);

      // Directed opening at the reset count: orphan copies, repeated holdings,
      // ties on replication, copy completion and an unused mode.
      send_item(item_of(MODE_REQUEST, 0, 63));
      send_item(item_of(MODE_REQUEST, 0, 0));
      send_item(item_of(MODE_HOLD, 31, 63));
      send_item(item_of(MODE_HOLD, 31, 63));
      send_item(item_of(MODE_HOLD, 0, 63));
      send_item(item_of(MODE_REQUEST, 31, 0));
      send_item(item_of(MODE_REQUEST, 0, 0));
      send_item(item_of(MODE_COPY_DONE, 0, 0));
      send_item(item_of(MODE_REQUEST, 0, 0));
      send_item(item_of(MODE_UNUSED, 31, 63));
      send_item(item_of(MODE_HOLD, 5, 62));
      send_item(item_of(MODE_HOLD, 31, 62));
      send_item(item_of(MODE_HOLD, 7, 61));
      send_item(item_of(MODE_HOLD, 31, 60));
      send_item(item_of(MODE_REQUEST, 7, 0));
      send_item(item_of(MODE_REQUEST, 31, 0));
      send_item(item_of(MODE_REQUEST, 31, 0));
      send_item(item_of(MODE_COPY_DONE, 3, 1));
      send_item(item_of(MODE_REQUEST, 3, 0));
      send_item(item_of(MODE_REQUEST, 5, 0));
      items_ignored = 1;

      // Random phases, one per fragment count; one phase runs with no gaps at all.
      for (int p = 0; p < PHASES; p++) begin
         set_fragment_count(phase_count[p]);
         active  = (int'(phase_count[p]) > FRAGMENTS) ? FRAGMENTS : int'(phase_count[p]);
         idle_on = (p != 4);
         useful  = 0;
         while (useful < phase_quota[p]) begin
            item = random_item(active, ignored);
            send_item(item);
            if (ignored) begin
               items_ignored++;
            end else begin
               useful++;
            end
         end
      end

      // Drain: every answer in, then allow for the longest request latency.
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0);
      repeat (80) @(posedge clock);

      $display("Sent %0d items (%0d of them ignored by the block) over %0d count settings.",
               items_sent, items_ignored, PHASES);
      $display("Answers checked: %0d search, %0d copy, %0d complete.",
               searches_seen, copies_seen, completes_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
